>>> src/lsd_radix_sorter_core_assert.svh
// Assertion macros for the radix sorter.
`ifndef LSD_RADIX_SORTER_CORE_ASSERT_SVH
`define LSD_RADIX_SORTER_CORE_ASSERT_SVH

// Checked on every clock edge outside reset.
`define LSDRS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define LSDRS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/lsdrs_pkg.sv
// ----------------------------------------------------------------------------
// lsdrs_pkg
// Shared types and constants of the radix sorter: payload structs, the
// command and status groups between controller and datapath, register map.
// ----------------------------------------------------------------------------
`default_nettype none

package lsdrs_pkg;

	// Configuration register map.
	localparam int          APB_AW        = 3;
	localparam logic        REG_IDX_RADIX = 1'b0;
	localparam int          RADIX_W       = 9;
	localparam logic [8:0]  RADIX_RST     = 9'd10;

	// Input transaction payload.
	typedef struct packed {
		logic [31:0] value;
		logic        last;
	} in_item_t;

	// Output transaction payload.
	typedef struct packed {
		logic [31:0] sorted_value;
		logic        end_of_set;
		logic        dropped;
	} out_item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic start;
		logic clr_wr;
		logic div_rd;
		logic div_go;
		logic div_wr;
		logic cnt_inc;
		logic pfx_rd;
		logic pfx_wr;
		logic pl_rd;
		logic pl_cr;
		logic pl_wr;
		logic span_go;
		logic span_wr;
		logic emit_rd;
		logic emit_ld;
		logic idx_up;
		logic idx_dn;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic idx_last;
		logic idx_first;
		logic bkt_last;
		logic div_busy;
		logic span_zero;
		logic out_free;
	} dp_stat_t;

endpackage

`default_nettype wire

>>> src/lsdrs_div.sv
// ----------------------------------------------------------------------------
// lsdrs_div
// Restoring divider, one quotient bit per cycle. Gives quotient and
// remainder of an unsigned dividend by a small unsigned divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module lsdrs_div import lsdrs_pkg::*; #(
	parameter int DW = 32,
	parameter int RW = 9
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [DW-1:0] dividend,
	input  wire logic [RW-1:0] divisor,
	output logic               busy,
	output logic [DW-1:0]      quot,
	output logic [RW-1:0]      rem
);

	localparam int CNTW = $clog2(DW + 1);

	logic [DW-1:0]   dvd_q;
	logic [RW-1:0]   rem_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic [RW:0]     trial;
	logic [RW:0]     diff;
	logic            fits;

	// One restoring step: shift in the next dividend bit and try a subtract.
	always_comb begin
		trial = {rem_q, dvd_q[DW-1]};
		diff  = trial - {1'b0, divisor};
		fits  = (trial >= {1'b0, divisor});
	end

	// Step counter and busy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNTW'(DW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNTW'(1);
			if (cnt_q == CNTW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Partial remainder and quotient shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DW-2:0], fits};
			rem_q <= fits ? diff[RW-1:0] : trial[RW-1:0];
		end
	end

	assign busy = busy_q;
	assign quot = dvd_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

>>> src/lsdrs_dpath.sv
// ----------------------------------------------------------------------------
// lsdrs_dpath
// Datapath of the radix sorter: element buffers, digit and bucket memories,
// min/max tracking, pass counters, the shared divider and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lsdrs_dpath import lsdrs_pkg::*; #(
	parameter int MAX_ELEMS  = 64,
	parameter int DATA_WIDTH = 32,
	parameter int MAX_RADIX  = 256
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire dp_cmd_t            cmd,
	input  wire in_item_t           in_data,
	input  wire logic [RADIX_W-1:0] radix,
	input  wire logic               out_stall,
	output logic                    out_valid,
	output out_item_t               out_data,
	output dp_stat_t                st
);

	localparam int DW        = DATA_WIDTH;
	localparam int IW        = $clog2(MAX_ELEMS);
	localparam int CW        = $clog2(MAX_ELEMS + 1);
	localparam int RW        = $clog2(MAX_RADIX + 1);
	localparam int DIGW      = $clog2(MAX_RADIX);
	localparam int BW        = IW + 1;
	localparam int BUF_DEPTH = 2 ** BW;
	localparam int DIG_DEPTH = 2 ** IW;
	localparam int CNT_DEPTH = 2 ** DIGW;

	// Memories: ping-pong element buffer holding {value, quotient}, digits, buckets.
	logic [2*DW-1:0] buf_mem [BUF_DEPTH];
	logic [DIGW-1:0] dig_mem [DIG_DEPTH];
	logic [CW-1:0]   cnt_mem [CNT_DEPTH];

	logic [2*DW-1:0] buf_rd_q;
	logic [DIGW-1:0] dig_rd_q;
	logic [CW-1:0]   cnt_rd_q;

	logic [CW-1:0]   n_q;
	logic            ovf_q;
	logic [DW-1:0]   min_q;
	logic [DW-1:0]   max_q;
	logic [RW-1:0]   base_q;
	logic [DW-1:0]   span_q;
	logic            first_q;
	logic            bank_q;
	logic [IW-1:0]   idx_q;
	logic [DIGW-1:0] bkt_q;
	logic [CW-1:0]   run_q;
	logic            out_valid_q;
	out_item_t       out_q;

	logic [DW-1:0]   v_in;
	logic            room;
	logic [RW-1:0]   base_sel;
	logic [DW-1:0]   val_rd;
	logic [DW-1:0]   quot_rd;
	logic [DW-1:0]   dividend;
	logic            div_start;
	logic            div_busy;
	logic [DW-1:0]   div_quot;
	logic [RW-1:0]   div_rem;
	logic [DIGW-1:0] digit;
	logic [CW-1:0]   pfx_sum;
	logic [CW-1:0]   pos;
	logic            idx_last;
	logic            idx_first;
	logic            bkt_last;

	logic            buf_we;
	logic [BW-1:0]   buf_wa;
	logic [2*DW-1:0] buf_wd;
	logic            cnt_we;
	logic [DIGW-1:0] cnt_wa;
	logic [CW-1:0]   cnt_wd;
	logic            cnt_re;
	logic [DIGW-1:0] cnt_ra;

	// Common decode.
	always_comb begin
		v_in      = DW'(in_data.value);
		room      = (n_q < CW'(MAX_ELEMS));
		val_rd    = buf_rd_q[2*DW-1:DW];
		quot_rd   = buf_rd_q[DW-1:0];
		digit     = div_rem[DIGW-1:0];
		pfx_sum   = run_q + cnt_rd_q;
		pos       = cnt_rd_q - CW'(1);
		idx_last  = (CW'(idx_q) == n_q - CW'(1));
		idx_first = (idx_q == '0);
		bkt_last  = (RW'(bkt_q) == base_q - RW'(1));
		if (radix < RADIX_W'(2)) begin
			base_sel = RW'(2);
		end else if (radix > RADIX_W'(MAX_RADIX)) begin
			base_sel = RW'(MAX_RADIX);
		end else begin
			base_sel = RW'(radix);
		end
	end

	// Divider operand: the span for span_go, else the offset value on the first pass and the running quotient after.
	always_comb begin
		if (cmd.span_go) begin
			dividend = span_q;
		end else if (first_q) begin
			dividend = val_rd - min_q;
		end else begin
			dividend = quot_rd;
		end
		div_start = cmd.div_go | cmd.span_go;
	end

	lsdrs_div #(
		.DW (DW),
		.RW (RW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (base_q),
		.busy     (div_busy),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	// Element buffer write port.
	always_comb begin
		buf_we = 1'b0;
		buf_wa = {bank_q, idx_q};
		buf_wd = {val_rd, div_quot};
		if (cmd.load && room) begin
			buf_we = 1'b1;
			buf_wa = {bank_q, n_q[IW-1:0]};
			buf_wd = {v_in, DW'(0)};
		end else if (cmd.div_wr) begin
			buf_we = 1'b1;
		end else if (cmd.pl_wr) begin
			buf_we = 1'b1;
			buf_wa = {~bank_q, pos[IW-1:0]};
			buf_wd = buf_rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (buf_we) begin
			buf_mem[buf_wa] <= buf_wd;
		end
		if (cmd.div_rd || cmd.pl_rd || cmd.emit_rd) begin
			buf_rd_q <= buf_mem[{bank_q, idx_q}];
		end
	end

	// Digit memory.
	always_ff @(posedge clk) begin
		if (cmd.div_wr) begin
			dig_mem[idx_q] <= digit;
		end
		if (cmd.pl_rd) begin
			dig_rd_q <= dig_mem[idx_q];
		end
	end

	// Bucket count memory ports.
	always_comb begin
		cnt_we = 1'b0;
		cnt_wa = bkt_q;
		cnt_wd = '0;
		if (cmd.clr_wr) begin
			cnt_we = 1'b1;
		end else if (cmd.cnt_inc) begin
			cnt_we = 1'b1;
			cnt_wa = digit;
			cnt_wd = cnt_rd_q + CW'(1);
		end else if (cmd.pfx_wr) begin
			cnt_we = 1'b1;
			cnt_wd = pfx_sum;
		end else if (cmd.pl_wr) begin
			cnt_we = 1'b1;
			cnt_wa = dig_rd_q;
			cnt_wd = pos;
		end
		cnt_re = cmd.div_wr | cmd.pfx_rd | cmd.pl_cr;
		if (cmd.div_wr) begin
			cnt_ra = digit;
		end else if (cmd.pl_cr) begin
			cnt_ra = dig_rd_q;
		end else begin
			cnt_ra = bkt_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[cnt_wa] <= cnt_wd;
		end
		if (cnt_re) begin
			cnt_rd_q <= cnt_mem[cnt_ra];
		end
	end

	// Set bookkeeping, pass control registers and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q     <= '0;
			ovf_q   <= 1'b0;
			first_q <= 1'b0;
			bank_q  <= 1'b0;
			idx_q   <= '0;
			bkt_q   <= '0;
		end else begin
			if (cmd.load) begin
				if (room) begin
					n_q <= n_q + CW'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.start) begin
				first_q <= 1'b1;
				idx_q   <= '0;
				bkt_q   <= '0;
			end
			if (cmd.span_go) begin
				first_q <= 1'b0;
				bank_q  <= ~bank_q;
			end
			if (cmd.clr_wr || cmd.pfx_wr) begin
				bkt_q <= bkt_last ? '0 : bkt_q + DIGW'(1);
			end
			if (cmd.idx_up) begin
				idx_q <= idx_last ? '0 : idx_q + IW'(1);
			end else if (cmd.idx_dn) begin
				idx_q <= idx_first ? IW'(n_q - CW'(1)) : idx_q - IW'(1);
			end
			if (cmd.emit_ld && idx_last) begin
				n_q   <= '0;
				ovf_q <= 1'b0;
			end
		end
	end

	// Data registers without reset.
	always_ff @(posedge clk) begin
		if (cmd.load && room) begin
			if (n_q == '0) begin
				min_q <= v_in;
				max_q <= v_in;
			end else if (v_in < min_q) begin
				min_q <= v_in;
			end else if (v_in > max_q) begin
				max_q <= v_in;
			end
		end
		if (cmd.start) begin
			base_q <= base_sel;
			span_q <= max_q - min_q;
		end
		if (cmd.span_wr) begin
			span_q <= div_quot;
		end
		if (cmd.clr_wr) begin
			run_q <= '0;
		end else if (cmd.pfx_wr) begin
			run_q <= pfx_sum;
		end
		if (cmd.emit_ld) begin
			out_q.sorted_value <= 32'(val_rd);
			out_q.end_of_set   <= idx_last;
			out_q.dropped      <= ovf_q;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_ld) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		st.idx_last  = idx_last;
		st.idx_first = idx_first;
		st.bkt_last  = bkt_last;
		st.div_busy  = div_busy;
		st.span_zero = (span_q == '0);
		st.out_free  = ~out_valid_q | ~out_stall;
	end

endmodule

`default_nettype wire

>>> src/lsdrs_ctrl.sv
// ----------------------------------------------------------------------------
// lsdrs_ctrl
// Controller of the radix sorter: sequences loading, the digit passes
// (clear, divide and count, prefix sum, placement, span division) and the emit phase.
// ----------------------------------------------------------------------------
`default_nettype none

module lsdrs_ctrl import lsdrs_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	input  wire logic     in_last,
	input  wire dp_stat_t st,
	output logic          in_stall,
	output dp_cmd_t       cmd
);

	localparam logic [4:0] S_LOAD  = 5'd0;
	localparam logic [4:0] S_START = 5'd1;
	localparam logic [4:0] S_CHK   = 5'd2;
	localparam logic [4:0] S_CLR   = 5'd3;
	localparam logic [4:0] S_DRD   = 5'd4;
	localparam logic [4:0] S_DGO   = 5'd5;
	localparam logic [4:0] S_DWT   = 5'd6;
	localparam logic [4:0] S_DWR   = 5'd7;
	localparam logic [4:0] S_DCNT  = 5'd8;
	localparam logic [4:0] S_PRD   = 5'd9;
	localparam logic [4:0] S_PWR   = 5'd10;
	localparam logic [4:0] S_LRD   = 5'd11;
	localparam logic [4:0] S_LCR   = 5'd12;
	localparam logic [4:0] S_LWR   = 5'd13;
	localparam logic [4:0] S_SGO   = 5'd14;
	localparam logic [4:0] S_SWT   = 5'd15;
	localparam logic [4:0] S_ERD   = 5'd16;
	localparam logic [4:0] S_ELD   = 5'd17;

	logic [4:0] state_q;
	logic [4:0] state_d;

	// Next state and command decode.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_LOAD: begin
				cmd.load = in_valid;
				if (in_valid && in_last) begin
					state_d = S_START;
				end
			end
			S_START: begin
				cmd.start = 1'b1;
				state_d   = S_CHK;
			end
			S_CHK: begin
				state_d = st.span_zero ? S_ERD : S_CLR;
			end
			S_CLR: begin
				cmd.clr_wr = 1'b1;
				if (st.bkt_last) begin
					state_d = S_DRD;
				end
			end
			S_DRD: begin
				cmd.div_rd = 1'b1;
				state_d    = S_DGO;
			end
			S_DGO: begin
				cmd.div_go = 1'b1;
				state_d    = S_DWT;
			end
			S_DWT: begin
				if (!st.div_busy) begin
					state_d = S_DWR;
				end
			end
			S_DWR: begin
				cmd.div_wr = 1'b1;
				state_d    = S_DCNT;
			end
			S_DCNT: begin
				cmd.cnt_inc = 1'b1;
				cmd.idx_up  = 1'b1;
				state_d     = st.idx_last ? S_PRD : S_DRD;
			end
			S_PRD: begin
				cmd.pfx_rd = 1'b1;
				state_d    = S_PWR;
			end
			S_PWR: begin
				cmd.pfx_wr = 1'b1;
				if (st.bkt_last) begin
					cmd.idx_dn = 1'b1;
					state_d    = S_LRD;
				end else begin
					state_d = S_PRD;
				end
			end
			S_LRD: begin
				cmd.pl_rd = 1'b1;
				state_d   = S_LCR;
			end
			S_LCR: begin
				cmd.pl_cr = 1'b1;
				state_d   = S_LWR;
			end
			S_LWR: begin
				cmd.pl_wr  = 1'b1;
				cmd.idx_dn = 1'b1;
				state_d    = st.idx_first ? S_SGO : S_LRD;
			end
			S_SGO: begin
				cmd.span_go = 1'b1;
				cmd.idx_up  = 1'b1;
				state_d     = S_SWT;
			end
			S_SWT: begin
				if (!st.div_busy) begin
					cmd.span_wr = 1'b1;
					state_d     = S_CHK;
				end
			end
			S_ERD: begin
				cmd.emit_rd = 1'b1;
				state_d     = S_ELD;
			end
			S_ELD: begin
				if (st.out_free) begin
					cmd.emit_ld = 1'b1;
					cmd.idx_up  = 1'b1;
					state_d     = st.idx_last ? S_LOAD : S_ERD;
				end
			end
			default: begin
				state_d = S_LOAD;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != S_LOAD);

endmodule

`default_nettype wire

>>> src/lsd_radix_sorter_core.sv
// ----------------------------------------------------------------------------
// lsd_radix_sorter_core
// Collects a set of unsigned elements and returns it in ascending order,
// using stable least-significant-digit radix passes in a programmable radix.
// ----------------------------------------------------------------------------
// Usage:
// Elements enter on the input channel (in_valid, in_stall, in_data), one
// transaction per cycle while the block is loading. The transaction with
// last set closes the set; elements beyond MAX_ELEMS are discarded and the
// results of that set report it in dropped.
// After the closing transaction in_stall stays high while the block sorts.
// Each digit pass runs the bit-serial divider over every element, which
// extracts one digit per element; there are ceil(log_radix(max-min+1))
// passes, none when all elements are equal.
// The sorted set then leaves on the output channel (out_valid, out_stall,
// out_data), one buffer read and one load per transaction, end_of_set on the last one.
// A stall on the output holds the current transaction and pauses emission.
// Reset empties the set, clears the output and sets radix to 10; the radix
// register is read at the start of each sort.
// ----------------------------------------------------------------------------
`default_nettype none

module lsd_radix_sorter_core import lsdrs_pkg::*; #(
	parameter int MAX_ELEMS  = 64,
	parameter int DATA_WIDTH = 32,
	parameter int MAX_RADIX  = 256
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire in_item_t          in_data,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output out_item_t              out_data,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);

	logic [RADIX_W-1:0] radix_q;
	logic               reg_sel;
	dp_cmd_t            cmd;
	dp_stat_t           st;

	// Configuration register.
	assign reg_sel = (paddr[APB_AW-1:2] == REG_IDX_RADIX);
	assign pready  = 1'b1;
	assign prdata  = reg_sel ? 32'(radix_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RST;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			radix_q <= pwdata[RADIX_W-1:0];
		end
	end

	lsdrs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_last  (in_data.last),
		.st       (st),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	lsdrs_dpath #(
		.MAX_ELEMS  (MAX_ELEMS),
		.DATA_WIDTH (DATA_WIDTH),
		.MAX_RADIX  (MAX_RADIX)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_data   (in_data),
		.radix     (radix_q),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data),
		.st        (st)
	);

	// Checks on the controller and datapath interplay.
`include "lsd_radix_sorter_core_assert.svh"

	`LSDRS_ASSERT(a_div_idle_on_start, (cmd.div_go || cmd.span_go) |-> !st.div_busy, "divider started while busy")
	`LSDRS_ASSERT(a_emit_into_free, cmd.emit_ld |-> st.out_free, "output register overwritten")
	`LSDRS_ASSERT(a_stall_after_last, (in_valid && !in_stall && in_data.last) |=> in_stall, "input not stalled after last element")
	`LSDRS_ASSERT_ALWAYS(a_reset_out_idle, !arst_n |-> !out_valid, "output valid during reset")

endmodule

`default_nettype wire
